// ===== sv/opflm_pkg.sv =====
package opflm_pkg;

   localparam logic [63:0] GOLDEN_SEED = 64'h9E3779B97F4A7C15;

   localparam int SAT_W  = 16;
   localparam int TEMP_W = 16;
   localparam int OUT_W  = 17;
   localparam int IDX_W  = 4;
   localparam int CSR_W  = 64;

   typedef enum logic [IDX_W-1:0] {
      REG_LAG_ALPHA     = 4'd0,
      REG_FRAME_PERIOD  = 4'd1,
      REG_DROPOUT_ON    = 4'd2,
      REG_IMPLAUSIBLE   = 4'd3,
      REG_STUCK_ON      = 4'd4,
      REG_NOISE_AMP     = 4'd5,
      REG_BUBBLE_OFFSET = 4'd6,
      REG_NOISE_SEED    = 4'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_TIMEOUT     = 3'd1,
      STATUS_FRAME_ERROR = 3'd2,
      STATUS_IMPLAUSIBLE = 3'd3,
      STATUS_STUCK       = 3'd4
   } status_type;

   typedef struct packed {
      logic [15:0]        lag_alpha;
      logic [15:0]        frame_period;
      logic               dropout_on;
      logic               implausible_on;
      logic               stuck_on;
      logic [11:0]        noise_amp;
      logic signed [12:0] bubble_offset;
   } cfg_type;

   typedef struct packed {
      logic [63:0]              noise_gen;
      logic [31:0]              lag;
      logic                     lag_primed;
      logic [15:0]              phase;
      logic signed [OUT_W-1:0]  last_sat;
      logic signed [OUT_W-1:0]  last_temp;
      logic                     last_valid;
   } state_type;

   typedef struct packed {
      status_type               status;
      logic signed [OUT_W-1:0]  sat;
      logic signed [OUT_W-1:0]  temp;
   } result_type;

   function automatic logic [63:0] xorshift_step(input logic [63:0] x);
      logic [63:0] a;
      logic [63:0] b;
      a = x ^ (x << 13);
      b = a ^ (a >> 7);
      return b ^ (b << 17);
   endfunction

   function automatic logic signed [OUT_W-1:0] clamp17(input logic signed [19:0] v);
      if (v > 20'sd65535) begin
         return 17'h0FFFF;
      end else if (v < -20'sd65536) begin
         return 17'h10000;
      end else begin
         return v[OUT_W-1:0];
      end
   endfunction

endpackage

// ===== sv/opflm_reading.sv =====
module opflm_reading import opflm_pkg::*; (
   input  cfg_type           cfg,
   input  state_type         state,
   input  logic [SAT_W-1:0]  tank_saturation,
   input  logic [TEMP_W-1:0] tank_temperature,
   output result_type        result,
   output state_type         state_next
);

   logic [31:0]        lag_base;
   logic [16:0]        one_minus_alpha;
   logic [48:0]        keep_part;
   logic [31:0]        new_part;
   logic [49:0]        mix;
   logic [31:0]        lag_new;
   logic [15:0]        phase_inc;
   logic               frame_err;
   logic [63:0]        gen1;
   logic [63:0]        gen2;
   logic [23:0]        r_sat;
   logic [23:0]        r_temp;
   logic [36:0]        sat_prod;
   logic [30:0]        temp_prod;
   logic signed [35:0] lag_term;
   logic signed [35:0] bubble_term;
   logic signed [35:0] amp_term;
   logic signed [35:0] noise_term;
   logic signed [35:0] total;
   logic signed [19:0] temp_sum;
   logic signed [OUT_W-1:0] good_sat;
   logic signed [OUT_W-1:0] good_temp;

   // first-order lag, first poll primes it
   assign lag_base        = state.lag_primed ? state.lag : {tank_saturation, 16'h0000};
   assign one_minus_alpha = 17'h10000 - {1'b0, cfg.lag_alpha};
   assign keep_part       = lag_base * one_minus_alpha;
   assign new_part        = tank_saturation * cfg.lag_alpha;
   assign mix             = {1'b0, keep_part} + {2'b00, new_part, 16'h0000};
   assign lag_new         = mix[47:16];

   assign phase_inc = state.phase + 16'd1;
   assign frame_err = (cfg.frame_period != 16'd0) && (phase_inc >= cfg.frame_period);

   // two draws per good reading: saturation first, then temperature
   assign gen1   = xorshift_step(state.noise_gen);
   assign gen2   = xorshift_step(gen1);
   assign r_sat  = gen1[63:40];
   assign r_temp = gen2[63:40];

   assign sat_prod  = r_sat * {cfg.noise_amp, 1'b0};
   assign temp_prod = r_temp * 7'd100;

   assign lag_term    = {4'b0000, lag_new};
   assign bubble_term = {{7{cfg.bubble_offset[12]}}, cfg.bubble_offset, 16'h0000};
   assign amp_term    = {8'h00, cfg.noise_amp, 16'h0000};
   assign noise_term  = {7'b0000000, sat_prod[36:8]};
   assign total       = lag_term + bubble_term - amp_term + noise_term;
   assign good_sat    = clamp17(total[35:16]);

   assign temp_sum  = $signed({4'b0000, tank_temperature})
                    + $signed({13'h0000, temp_prod[30:24]}) - 20'sd50;
   assign good_temp = clamp17(temp_sum);

   always_comb begin
      state_next            = state;
      state_next.lag        = lag_new;
      state_next.lag_primed = 1'b1;
      state_next.phase      = frame_err ? 16'd0 : phase_inc;
      result.status         = STATUS_OK;
      result.sat            = '0;
      result.temp           = '0;
      if (cfg.dropout_on) begin
         result.status = STATUS_TIMEOUT;
      end else if (frame_err) begin
         result.status = STATUS_FRAME_ERROR;
      end else if (cfg.implausible_on) begin
         result.status = STATUS_IMPLAUSIBLE;
      end else if (cfg.stuck_on && state.last_valid) begin
         result.status = STATUS_STUCK;
         result.sat    = state.last_sat;
         result.temp   = state.last_temp;
      end else begin
         result.sat            = good_sat;
         result.temp           = good_temp;
         state_next.noise_gen  = gen2;
         state_next.last_sat   = good_sat;
         state_next.last_temp  = good_temp;
         state_next.last_valid = 1'b1;
      end
   end

endmodule

// ===== sv/oxygen_probe_fault_lag_model.sv =====
// Dissolved-oxygen probe emulator. Each req item is one poll carrying the
// true tank saturation (1/256 percent) and temperature (millidegrees C); each
// poll yields exactly one rsp item with status, saturation and temperature.
// A poll passes an input register and a result register, so its result is
// offered on rsp once it has passed both; while rsp is not stalled, one poll
// can be taken every cycle, and the combinational lag and noise-generator
// update between the two registers sets that rate. Faults are reported in the
// order timeout, frame error, implausible, stuck. Any write to a defined register
// restarts the frame-error phase; write registers only while no poll is in flight.
module oxygen_probe_fault_lag_model import opflm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,   // tank_saturation[15:0], tank_temperature[31:16]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata,   // reported_saturation[16:0], reported_temperature[33:17]
   output logic [2:0]        rsp_tuser,   // poll_status[2:0]
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]  csr_data
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   state_type   state_ff;
   state_type   state_in;
   state_type   state_next;
   result_type  result;
   logic        req_valid_ff;
   logic [31:0] req_data_ff;
   logic        rsp_valid_ff;
   result_type  rsp_result_ff;
   logic        advance;
   logic        csr_fire;

   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   opflm_reading u_reading (
      .cfg              (cfg_ff),
      .state            (state_ff),
      .tank_saturation  (req_data_ff[15:0]),
      .tank_temperature (req_data_ff[31:16]),
      .result           (result),
      .state_next       (state_next)
   );

   always_comb begin
      cfg_in   = cfg_ff;
      state_in = state_ff;
      if (advance) begin
         state_in = state_next;
      end
      if (csr_fire) begin
         state_in.phase = 16'd0;
         case (csr_index)
            REG_LAG_ALPHA:     cfg_in.lag_alpha      = csr_data[15:0];
            REG_FRAME_PERIOD:  cfg_in.frame_period   = csr_data[15:0];
            REG_DROPOUT_ON:    cfg_in.dropout_on     = csr_data[0];
            REG_IMPLAUSIBLE:   cfg_in.implausible_on = csr_data[0];
            REG_STUCK_ON:      cfg_in.stuck_on       = csr_data[0];
            REG_NOISE_AMP:     cfg_in.noise_amp      = csr_data[11:0];
            REG_BUBBLE_OFFSET: cfg_in.bubble_offset  = csr_data[12:0];
            REG_NOISE_SEED: begin
               state_in.noise_gen = (csr_data != '0) ? csr_data : GOLDEN_SEED;
            end
            default: begin
               state_in.phase = state_ff.phase;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lag_alpha      <= 16'hFFFF;
         cfg_ff.frame_period   <= 16'd0;
         cfg_ff.dropout_on     <= 1'b0;
         cfg_ff.implausible_on <= 1'b0;
         cfg_ff.stuck_on       <= 1'b0;
         cfg_ff.noise_amp      <= 12'd0;
         cfg_ff.bubble_offset  <= 13'sd0;
         state_ff.noise_gen    <= GOLDEN_SEED;
         state_ff.lag          <= 32'd0;
         state_ff.lag_primed   <= 1'b0;
         state_ff.phase        <= 16'd0;
         state_ff.last_sat     <= '0;
         state_ff.last_temp    <= '0;
         state_ff.last_valid   <= 1'b0;
         req_valid_ff          <= 1'b0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         cfg_ff   <= cfg_in;
         state_ff <= state_in;
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_data_ff <= req_tdata;
      end
      if (advance) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_result_ff.status;
   assign rsp_tdata  = {6'b000000, rsp_result_ff.temp, rsp_result_ff.sat};

endmodule
